// File: sv/rsac_pkg.sv
`timescale 1ns / 1ps

package rsac_pkg;

   // Error codes carried on the result channel.
   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_DIGIT    = 2'd1,
      ERR_OVERFLOW = 2'd2
   } rsac_err_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_BASE_FIRST  = 2'd0,
      CSR_BASE_SECOND = 2'd1,
      CSR_BASE_OUT    = 2'd2
   } rsac_csr_type;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_F    = 8'h46;
   localparam int         DEC_RADIX = 10;
   localparam logic [4:0] RADIX_MIN = 5'd2;
   localparam logic [4:0] RADIX_MAX = 5'd16;
   localparam logic [4:0] DIGIT_BAD = 5'd16;
   localparam logic [4:0] BASE_RESET = 5'd10;

   // Commands from the sequencer to the serial divider.
   typedef struct packed {
      logic start;
      logic load;
   } rsac_div_ctrl_type;

   // Status of the serial divider; valid while done is high.
   typedef struct packed {
      logic       done;
      logic       nonzero;
      logic [3:0] rem;
   } rsac_div_status_type;

   // Limit a radix register to the range 2 to 16.
   function automatic logic [4:0] clamp_base(input logic [4:0] b);
      logic [4:0] r;
      r = b;
      if (b < RADIX_MIN) r = RADIX_MIN;
      if (b > RADIX_MAX) r = RADIX_MAX;
      return r;
   endfunction

   // Digit value of an ASCII character, or DIGIT_BAD when it is not a digit.
   function automatic logic [4:0] char_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'(DIGIT_BAD);
      if (c >= CHAR_ZERO && c < CHAR_ZERO + 8'(DEC_RADIX)) v = c - CHAR_ZERO;
      else if (c >= CHAR_A && c <= CHAR_F) v = c - CHAR_A + 8'(DEC_RADIX);
      return v[4:0];
   endfunction

   // ASCII character of a digit value from 0 to 15.
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] r;
      if (d > 4'(DEC_RADIX - 1)) r = CHAR_A + {4'b0, d} - 8'(DEC_RADIX);
      else r = CHAR_ZERO + {4'b0, d};
      return r;
   endfunction

endpackage

// File: sv/rsac_serial_div.sv
`timescale 1ns / 1ps

module rsac_serial_div
   import rsac_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rsac_div_ctrl_type       ctrl,
   input  logic [VALUE_BITS-1:0]   dividend,
   input  logic [4:0]              divisor,
   output rsac_div_status_type     status
);

   localparam int BW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [3:0]            rem_ff, rem_in;
   logic [BW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  nz_ff, nz_in;

   logic [4:0] trial;
   logic [4:0] diff;
   logic       ge;

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   assign trial = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign ge    = (trial >= divisor);
   assign diff  = trial - divisor;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      nz_in   = nz_ff;
      if (ctrl.start) begin
         if (ctrl.load) quo_in = dividend;
         rem_in  = 4'd0;
         cnt_in  = '0;
         nz_in   = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], ge};
         rem_in = ge ? diff[3:0] : trial[3:0];
         nz_in  = nz_ff | ge;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == BW'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      nz_ff  <= nz_in;
   end

   assign status.done    = done_ff;
   assign status.nonzero = nz_ff;
   assign status.rem     = rem_ff;

endmodule

// File: sv/radix_string_add_and_convert.sv
`timescale 1ns / 1ps

// Adds two unsigned numbers given as ASCII digit strings, each in its own radix
// (2 to 16), and returns the sum as ASCII digits in the output radix, most
// significant first, the final one marked by rsp_tlast. Only '0'-'9' and 'A'-'F'
// are digits; a bad digit or a value beyond VALUE_BITS bits yields one result
// with data zero and the error code on rsp_tuser. The datapath is bit-serial:
// a valid character runs one Horner step over the operand one bit per cycle,
// and an invalid one is marked as an error with no Horner step. After the final
// character of the second operand the block runs the serial sum, starts the
// divider, runs the restoring divider once per output digit, then reads each
// digit back from the digit store into a register and presents it. One request
// is handled at a time; req_tready is high only while the block waits.
module radix_string_add_and_convert
   import rsac_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   // Request channel.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] digit_char
   input  logic       req_tuser,   // [0] second_operand
   input  logic       req_tlast,   // last_char
   // Result channel.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [1:0] rsp_tuser,   // [1:0] error_code
   output logic       rsp_tlast,   // last_digit
   // Configuration write channel.
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_data
);

   localparam int BW    = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int DEPTH = VALUE_BITS + 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_HORNER   = 8'b0000_0010,
      ST_ADD      = 8'b0000_0100,
      ST_DIV_LOAD = 8'b0000_1000,
      ST_DIV_RUN  = 8'b0001_0000,
      ST_EMIT_RD  = 8'b0010_0000,
      ST_EMIT_OUT = 8'b0100_0000,
      ST_ERR_OUT  = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [4:0]            base_first_ff, base_first_in;
   logic [4:0]            base_second_ff, base_second_in;
   logic [4:0]            base_out_ff, base_out_in;
   logic [VALUE_BITS-1:0] first_ff, first_in;
   logic [VALUE_BITS-1:0] second_ff, second_in;
   rsac_err_type          sticky_ff, sticky_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [BW-1:0]         bit_ff, bit_in;
   logic [3:0]            carry_ff, carry_in;
   logic                  sec_ff, sec_in;
   logic                  last_ff, last_in;
   logic [IDX_W-1:0]      rd_addr_ff, rd_addr_in;
   logic [3:0]            rd_data_ff;
   logic [3:0]            digit_store [DEPTH];

   rsac_div_ctrl_type     div_ctrl;
   rsac_div_status_type   div_status;
   logic                  wr_en;

   logic                  req_acc, rsp_acc;
   logic [4:0]            in_digit;
   logic [4:0]            in_base;
   logic [4:0]            acc_base;
   logic                  acc_bit;
   logic [4:0]            horner_sum;
   logic                  sum_bit;
   logic                  add_cout;
   logic                  bit_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_acc    = rsp_tvalid & rsp_tready;

   // Digit check for the incoming character.
   assign in_digit = char_value(req_tdata);
   assign in_base  = req_tuser ? clamp_base(base_second_ff) : clamp_base(base_first_ff);

   // Serial Horner step: value * base + digit, LSB first, carry below 16.
   assign acc_base   = sec_ff ? clamp_base(base_second_ff) : clamp_base(base_first_ff);
   assign acc_bit    = sec_ff ? second_ff[0] : first_ff[0];
   assign horner_sum = {1'b0, carry_ff} + (acc_bit ? acc_base : 5'd0);

   // Serial sum of the two operands, LSB first.
   assign sum_bit  = first_ff[0] ^ second_ff[0] ^ carry_ff[0];
   assign add_cout = (first_ff[0] & second_ff[0]) | (carry_ff[0] & (first_ff[0] ^ second_ff[0]));
   assign bit_last = (bit_ff == BW'(VALUE_BITS - 1));

   always_comb begin
      state_in       = state_ff;
      base_first_in  = base_first_ff;
      base_second_in = base_second_ff;
      base_out_in    = base_out_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      sticky_in      = sticky_ff;
      count_in       = count_ff;
      bit_in         = bit_ff;
      carry_in       = carry_ff;
      sec_in         = sec_ff;
      last_in        = last_ff;
      rd_addr_in     = rd_addr_ff;
      div_ctrl       = '0;
      wr_en          = 1'b0;

      // Register writes.
      if (csr_valid & csr_ready) begin
         unique case (csr_index)
            CSR_BASE_FIRST:  base_first_in  = csr_data;
            CSR_BASE_SECOND: base_second_in = csr_data;
            CSR_BASE_OUT:    base_out_in    = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               sec_in  = req_tuser;
               last_in = req_tlast;
               bit_in  = '0;
               if (in_digit >= in_base) begin
                  if (sticky_ff == ERR_NONE) sticky_in = ERR_DIGIT;
                  if (req_tuser & req_tlast) state_in = ST_ERR_OUT;
               end else begin
                  carry_in = in_digit[3:0];
                  state_in = ST_HORNER;
               end
            end
         end

         ST_HORNER: begin
            carry_in = horner_sum[4:1];
            if (sec_ff) second_in = {horner_sum[0], second_ff[VALUE_BITS-1:1]};
            else first_in = {horner_sum[0], first_ff[VALUE_BITS-1:1]};
            bit_in = bit_ff + 1'b1;
            if (bit_last) begin
               if (horner_sum[4:1] != 4'd0 && sticky_ff == ERR_NONE) sticky_in = ERR_OVERFLOW;
               carry_in = 4'd0;
               bit_in   = '0;
               state_in = (sec_ff & last_ff) ? ST_ADD : ST_IDLE;
            end
         end

         ST_ADD: begin
            first_in  = {sum_bit, first_ff[VALUE_BITS-1:1]};
            second_in = {1'b0, second_ff[VALUE_BITS-1:1]};
            carry_in  = {3'b0, add_cout};
            bit_in    = bit_ff + 1'b1;
            if (bit_last) begin
               carry_in = 4'd0;
               bit_in   = '0;
               if (sticky_ff != ERR_NONE) begin
                  state_in = ST_ERR_OUT;
               end else if (add_cout) begin
                  sticky_in = ERR_OVERFLOW;
                  state_in  = ST_ERR_OUT;
               end else begin
                  state_in = ST_DIV_LOAD;
               end
            end
         end

         ST_DIV_LOAD: begin
            div_ctrl.start = 1'b1;
            div_ctrl.load  = 1'b1;
            count_in       = '0;
            state_in       = ST_DIV_RUN;
         end

         // Each finished division leaves one digit, least significant first.
         ST_DIV_RUN: begin
            if (div_status.done) begin
               if (count_ff < CNT_W'(DEPTH)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (div_status.nonzero) begin
                  div_ctrl.start = 1'b1;
               end else begin
                  rd_addr_in = IDX_W'(count_ff);
                  state_in   = ST_EMIT_RD;
               end
            end
         end

         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end

         ST_EMIT_OUT: begin
            if (rsp_acc) begin
               if (rd_addr_ff == '0) begin
                  first_in  = '0;
                  second_in = '0;
                  sticky_in = ERR_NONE;
                  count_in  = '0;
                  state_in  = ST_IDLE;
               end else begin
                  rd_addr_in = rd_addr_ff - 1'b1;
                  state_in   = ST_EMIT_RD;
               end
            end
         end

         ST_ERR_OUT: begin
            if (rsp_acc) begin
               first_in  = '0;
               second_in = '0;
               sticky_in = ERR_NONE;
               count_in  = '0;
               state_in  = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         base_first_ff  <= BASE_RESET;
         base_second_ff <= BASE_RESET;
         base_out_ff    <= BASE_RESET;
         first_ff       <= '0;
         second_ff      <= '0;
         sticky_ff      <= ERR_NONE;
         count_ff       <= '0;
         bit_ff         <= '0;
         carry_ff       <= 4'd0;
      end else begin
         state_ff       <= state_in;
         base_first_ff  <= base_first_in;
         base_second_ff <= base_second_in;
         base_out_ff    <= base_out_in;
         first_ff       <= first_in;
         second_ff      <= second_in;
         sticky_ff      <= sticky_in;
         count_ff       <= count_in;
         bit_ff         <= bit_in;
         carry_ff       <= carry_in;
      end
      sec_ff     <= sec_in;
      last_ff    <= last_in;
      rd_addr_ff <= rd_addr_in;
   end

   // Digit store: written by the divider sequence, read back most significant first.
   always_ff @(posedge clock) begin
      if (wr_en) digit_store[count_ff[IDX_W-1:0]] <= div_status.rem;
      rd_data_ff <= digit_store[rd_addr_ff];
   end

   rsac_serial_div #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (first_ff),
      .divisor  (clamp_base(base_out_ff)),
      .status   (div_status)
   );

   // Result channel.
   assign rsp_tvalid = (state_ff == ST_EMIT_OUT) | (state_ff == ST_ERR_OUT);
   assign rsp_tdata  = (state_ff == ST_EMIT_OUT) ? digit_char(rd_data_ff) : 8'd0;
   assign rsp_tuser  = (state_ff == ST_ERR_OUT) ? sticky_ff : ERR_NONE;
   assign rsp_tlast  = (state_ff == ST_ERR_OUT) | (rd_addr_ff == '0);

endmodule

// File: sim/radix_string_add_and_convert_tb.sv
`timescale 1ns / 1ps

module radix_string_add_and_convert_tb;
   import rsac_pkg::*;

   localparam int          VALUE_BITS    = 32;
   localparam logic [63:0] VALUE_LIMIT   = (64'd1 << VALUE_BITS) - 64'd1;
   // A character that yields no result may still be in the serial datapath.
   localparam int          SETTLE_CYCLES = 2 * VALUE_BITS + 16;
   localparam int          STALL_LIMIT   = 20000;
   localparam int          PHASE_ITEMS   = 15;

   // One expected sum digit, or one error result.
   typedef struct {
      logic [7:0]   ch;
      logic         tail;
      rsac_err_type code;
   } sum_digit_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] digit_char
   logic       req_tuser;   // [0] second_operand
   logic       req_tlast;   // last_char
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] out_char
   logic [1:0] rsp_tuser;   // [1:0] error_code
   logic       rsp_tlast;   // last_digit
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [4:0] csr_data;

   radix_string_add_and_convert #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Shadow of the block's radix registers and run state.
   logic [4:0]    radix_first_reg;
   logic [4:0]    radix_second_reg;
   logic [4:0]    radix_out_reg;
   logic [63:0]   first_acc;
   logic [63:0]   second_acc;
   rsac_err_type  run_error;
   sum_digit_type expected_digits[$];

   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int error_count     = 0;
   int requests_sent   = 0;
   int results_checked = 0;
   int runs_closed     = 0;
   int idle_cycles     = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Radix registers outside 2 to 16 act as the nearest limit.
   function automatic logic [4:0] effective_radix(input logic [4:0] r);
      if (r < RADIX_MIN) return RADIX_MIN;
      if (r > RADIX_MAX) return RADIX_MAX;
      return r;
   endfunction

   // Value of an ASCII digit, or DIGIT_BAD for anything but '0'-'9' and 'A'-'F'.
   function automatic logic [4:0] char_digit(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_ZERO + 8'd9) return 5'(c - CHAR_ZERO);
      if (c >= CHAR_A && c <= CHAR_F) return 5'(c - CHAR_A + 8'd10);
      return DIGIT_BAD;
   endfunction

   function automatic logic [7:0] digit_glyph(input logic [3:0] d);
      return (d < 4'd10) ? CHAR_ZERO + 8'(d) : CHAR_A + 8'(d) - 8'd10;
   endfunction

   // Only the first error of a run is kept.
   function automatic void note_error(input rsac_err_type e);
      if (run_error == ERR_NONE) run_error = e;
   endfunction

   function automatic void clear_run();
      first_acc  = 64'd0;
      second_acc = 64'd0;
      run_error  = ERR_NONE;
   endfunction

   // One Horner step; the accumulator is left alone when the digit fails.
   function automatic void horner_step(inout logic [63:0] acc, input logic [4:0] radix,
                                       input logic [7:0] c);
      logic [63:0] d;
      d = 64'(char_digit(c));
      if (d >= 64'(radix)) note_error(ERR_DIGIT);
      else if (acc > (VALUE_LIMIT - d) / 64'(radix)) note_error(ERR_OVERFLOW);
      else acc = acc * 64'(radix) + d;
   endfunction

   // Works out the results that one accepted request causes.
   function automatic void predict_sum(input logic [7:0] c, input logic second,
                                       input logic last);
      logic [63:0]   q;
      logic [63:0]   radix;
      logic [3:0]    digits[$];
      sum_digit_type item;
      if (second) horner_step(second_acc, effective_radix(radix_second_reg), c);
      else horner_step(first_acc, effective_radix(radix_first_reg), c);
      if (!second || !last) return;
      runs_closed++;
      if (run_error == ERR_NONE && first_acc > VALUE_LIMIT - second_acc)
         note_error(ERR_OVERFLOW);
      if (run_error != ERR_NONE) begin
         item.ch   = 8'd0;
         item.tail = 1'b1;
         item.code = run_error;
         expected_digits.push_back(item);
         clear_run();
         return;
      end
      radix = 64'(effective_radix(radix_out_reg));
      q     = first_acc + second_acc;
      do begin
         digits.push_front(4'(q % radix));
         q = q / radix;
      end while (q != 64'd0);
      foreach (digits[k]) begin
         item.ch   = digit_glyph(digits[k]);
         item.tail = (k == digits.size() - 1);
         item.code = ERR_NONE;
         expected_digits.push_back(item);
      end
      clear_run();
   endfunction

   // Sends one character request, with a random gap ahead of it.
   task automatic send_char(input logic [7:0] c, input logic second, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= second;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_sum(c, second, last);
      requests_sent++;
      @(negedge clock);
   endtask

   // Holds requests back until every expected result has arrived, then lets the block settle.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_digits.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes all three radix registers back to back.
   task automatic set_radices(input logic [4:0] rf, input logic [4:0] rs,
                              input logic [4:0] ro);
      logic [4:0]   vals[3];
      rsac_csr_type idx;
      vals = '{rf, rs, ro};
      for (int i = 0; i < 3; i++) begin
         idx = rsac_csr_type'(i);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx)
            CSR_BASE_FIRST: begin
               radix_first_reg = vals[i];
            end
            CSR_BASE_SECOND: begin
               radix_second_reg = vals[i];
            end
            default: begin
               radix_out_reg = vals[i];
            end
         endcase
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly short strings; some fill the value width and a few overrun it.
   function automatic int random_length(input logic [4:0] radix, input int shortest);
      int          fit;
      int          pick;
      logic [63:0] v;
      fit = 0;
      v   = VALUE_LIMIT;
      while (v != 64'd0) begin
         v = v / 64'(radix);
         fit++;
      end
      pick = $urandom_range(99);
      if (pick < 12) return $urandom_range(fit + 3, fit + 1);
      if (pick < 30) return $urandom_range(fit, shortest);
      return $urandom_range((fit < 4) ? fit : 4, shortest);
   endfunction

   // A digit legal for the radix, now and then a digit too large or any byte at all.
   function automatic logic [7:0] random_digit(input logic [4:0] radix, input bit zeros);
      int pick;
      pick = $urandom_range(99);
      if (pick < 4) return 8'($urandom_range(255));
      if (pick < 7 && radix < RADIX_MAX)
         return digit_glyph(4'($urandom_range(15, int'(radix))));
      if (zeros) return CHAR_ZERO;
      return digit_glyph(4'($urandom_range(int'(radix) - 1)));
   endfunction

   // One run: a first string, usually closed on its final character, then a second one.
   task automatic send_random_run();
      int         first_len;
      int         second_len;
      int         first_mark;
      logic [4:0] rf;
      logic [4:0] rs;
      bit         zeros;
      rf         = effective_radix(radix_first_reg);
      rs         = effective_radix(radix_second_reg);
      zeros      = ($urandom_range(99) < 6);
      first_len  = random_length(rf, 0);
      second_len = random_length(rs, 1);
      first_mark = ($urandom_range(99) < 85) ? first_len - 1 : $urandom_range(first_len);
      for (int k = 0; k < first_len; k++)
         send_char(random_digit(rf, zeros), 1'b0, k == first_mark);
      for (int k = 0; k < second_len; k++)
         send_char(random_digit(rs, zeros), 1'b1, k == second_len - 1);
   endtask

   // Reset radices: a zero sum and a plain decimal sum.
   task automatic test_reset_defaults();
      send_char("0", 1'b0, 1'b1);
      send_char("0", 1'b1, 1'b1);
      send_char("1", 1'b0, 1'b0);
      send_char("2", 1'b0, 1'b1);
      send_char("3", 1'b1, 1'b0);
      send_char("4", 1'b1, 1'b1);
   endtask

   // An empty first operand, and first-operand characters after its final one.
   task automatic test_first_operand_cases();
      send_char("7", 1'b1, 1'b1);
      send_char("1", 1'b0, 1'b1);
      send_char("2", 1'b0, 1'b0);
      send_char("5", 1'b1, 1'b1);
   endtask

   // Lower-case and non-digit bytes, a digit beyond the radix, then a clean run.
   task automatic test_bad_characters();
      send_char("a", 1'b0, 1'b0);
      send_char(8'hFF, 1'b0, 1'b1);
      send_char("A", 1'b1, 1'b1);
      send_char("9", 1'b1, 1'b1);
   endtask

   // The largest hexadecimal first operand plus one overflows the sum.
   task automatic test_sum_overflow();
      wait_for_results();
      set_radices(5'd16, 5'd16, 5'd2);
      for (int k = 0; k < 8; k++) send_char("F", 1'b0, k == 7);
      send_char("1", 1'b1, 1'b1);
   endtask

   // One radix setting with random runs, stray requests and occasional full pauses.
   task automatic test_random_traffic(input logic [4:0] rf, input logic [4:0] rs,
                                      input logic [4:0] ro);
      int start;
      wait_for_results();
      set_radices(rf, rs, ro);
      start = requests_sent;
      while (requests_sent - start < PHASE_ITEMS) begin
         if ($urandom_range(99) < 10)
            send_char(8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
         else
            send_random_run();
         if ($urandom_range(99) < 5) wait_for_results();
      end
   endtask

   // Result side: ready drops at random as the idling pattern asks.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Each accepted result is compared with the oldest expected one.
   always @(posedge clock) begin
      sum_digit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (expected_digits.size() == 0) begin
            $error("result with none expected: out_char %h, last_digit %b, error_code %0d",
                   rsp_tdata, rsp_tlast, rsp_tuser);
            error_count++;
         end else begin
            want = expected_digits.pop_front();
            if (rsp_tdata !== want.ch) begin
               $error("out_char: expected %h, got %h", want.ch, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.tail) begin
               $error("last_digit: expected %b, got %b", want.tail, rsp_tlast);
               error_count++;
            end
            if (rsp_tuser !== want.code) begin
               $error("error_code: expected %0d, got %0d", want.code, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // Ends the run when no request, result or register write has gone through for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("radix_string_add_and_convert_tb: done, errors");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'd0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_BASE_FIRST;
      csr_data   = 5'd0;
      radix_first_reg  = BASE_RESET;
      radix_second_reg = BASE_RESET;
      radix_out_reg    = BASE_RESET;
      clear_run();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Slow sender, slower receiver.
      send_idle_pct = 22;
      recv_idle_pct = 80;
      test_reset_defaults();
      test_first_operand_cases();
      test_bad_characters();
      test_sum_overflow();
      test_random_traffic(5'd2, 5'd16, 5'd2);
      test_random_traffic(5'd16, 5'd2, 5'd16);
      test_random_traffic(5'd7, 5'd13, 5'd10);

      // Slow sender, quick receiver; register values outside the legal range.
      send_idle_pct = 80;
      recv_idle_pct = 22;
      test_random_traffic(5'd0, 5'd31, 5'd1);
      test_random_traffic(5'd17, 5'd1, 5'd31);
      test_random_traffic(5'd3, 5'd5, 5'd9);

      // No idling on either side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(5'd16, 5'd16, 5'd16);
      test_random_traffic(5'd2, 5'd2, 5'd2);
      test_random_traffic(5'($urandom_range(31)), 5'($urandom_range(31)),
                          5'($urandom_range(31)));

      wait_for_results();
      $display("Checked %0d results from %0d requests over %0d completed runs,",
               results_checked, requests_sent, runs_closed);
      $display("across eleven radix settings, clamped ones included, and three idling patterns.");
      if (error_count == 0)
         $display("radix_string_add_and_convert_tb: done, clean");
      else
         $display("radix_string_add_and_convert_tb: done, errors");
      $finish;
   end

endmodule
